// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/aras_pkg.sv =====
// Types and constants shared by the auto-ranging average scaler files.
package aras_pkg;

   localparam int LEVEL_BITS = 8;
   localparam int LAST_BITS  = 9;
   localparam logic [LAST_BITS-1:0] NO_LEVEL = '1;
   localparam int LEVEL_MAX  = 255;
   localparam int LOW_RESET  = 250;
   localparam int HIGH_RESET = 3000;
   localparam int LOW_MUL    = 21;
   localparam int HIGH_MUL   = 19;
   localparam int BOUND_DIV  = 20;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_LOW_GO,
      ST_LOW_RUN,
      ST_HIGH_GO,
      ST_HIGH_RUN,
      ST_AVG_GO,
      ST_AVG_RUN,
      ST_SCALE_GO,
      ST_SCALE_RUN,
      ST_OUT
   } aras_state_type;

endpackage

// ===== hdl/auto_ranging_average_scaler.sv =====
// Top level of the auto-ranging moving-average scaler for one color channel.
//
// One sample enters on the req_ channel per transfer, and exactly one result
// (level, changed, range_empty) leaves on the rsp_ channel for each sample.
// The block handles one sample at a time: req_ready is high only while it
// waits for a sample. The sample history sits in a memory with one valid bit
// per entry, so reset empties it at once and the block is ready in the next
// cycle. Bound updates, the average and the final scaling all go through one
// bit-serial restoring divider that retires one quotient bit per cycle.
// Each sample needs the average division and, only where called for, a low
// bound update, a high bound update and the scaling division. req_ready rises
// in the same cycle as rsp_valid, so the next sample can be taken at once.
// A finished result waits in the output register while the receiver
// stalls, and a new sample may already be taken in; its own result is held
// back until the previous transfer completes.
module auto_ranging_average_scaler
   import aras_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_BITS-1:0]  rsp_level,
   output logic                   rsp_changed,
   output logic                   rsp_range_empty
);

   localparam int SW   = SAMPLE_BITS;
   localparam int BW   = SAMPLE_BITS + 1;
   localparam int PW   = $clog2(WINDOW_DEPTH);
   localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int NW   = BW + LEVEL_BITS;
   localparam int DW   = BW;
   localparam int CW   = $clog2(NW + 1);

   aras_state_type state_ff, state_in;

   logic [SW-1:0]         samp_ff, samp_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [SW-1:0]         hist_mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] hist_vld_ff;
   logic [SW-1:0]         old_ff;
   logic                  old_vld_ff;
   logic [SUMW-1:0]       sum_ff, sum_in;
   logic [BW-1:0]         low_ff, low_in;
   logic [BW-1:0]         high_ff, high_in;
   logic [SW-1:0]         avg_ff, avg_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic                  empty_ff, empty_in;
   logic [LAST_BITS-1:0]  last_ff, last_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         quo_ff, quo_in;
   logic [DW-1:0]         div_ff, div_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  accept;
   logic [DW:0]           trial;
   logic [DW:0]           trial_diff;
   logic                  trial_ge;
   logic [BW:0]           num_sv;
   logic [BW:0]           num_neg;
   logic [BW-1:0]         num_mag;
   logic [BW:0]           den_sv;
   logic [BW:0]           den_neg;
   logic [BW-1:0]         den_mag;
   logic                  div_load;
   logic [NW-1:0]         load_num;
   logic [DW-1:0]         load_den;

   assign accept     = req_valid && req_ready;
   assign trial      = {rem_ff, quo_ff[NW-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign trial_ge   = trial >= {1'b0, div_ff};
   assign num_sv     = {2'b00, avg_ff} - {1'b0, low_ff};
   assign num_neg    = ~num_sv + 1'b1;
   assign num_mag    = num_sv[BW] ? num_neg[BW-1:0] : num_sv[BW-1:0];
   assign den_sv     = {1'b0, high_ff} - {1'b0, low_ff};
   assign den_neg    = ~den_sv + 1'b1;
   assign den_mag    = den_sv[BW] ? den_neg[BW-1:0] : den_sv[BW-1:0];

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_range_empty = rsp_empty_ff;

   always_comb begin
      state_in       = state_ff;
      samp_in        = samp_ff;
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      avg_in         = avg_ff;
      level_in       = level_ff;
      empty_in       = empty_ff;
      last_in        = last_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      div_in         = div_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_level_in   = rsp_level_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_empty_in   = rsp_empty_ff;
      div_load       = 1'b0;
      load_num       = '0;
      load_den       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_in  = req_sample;
               pos_in   = (pos_ff == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sum_ff - (old_vld_ff ? SUMW'(old_ff) : '0) + SUMW'(samp_ff);
            state_in = ST_LOW_GO;
         end
         ST_LOW_GO: begin
            if ({1'b0, samp_ff} < low_ff) begin
               div_load = 1'b1;
               load_num = NW'(samp_ff) * NW'(LOW_MUL);
               load_den = DW'(BOUND_DIV);
               state_in = ST_LOW_RUN;
            end else begin
               state_in = ST_HIGH_GO;
            end
         end
         ST_LOW_RUN: begin
            if (cnt_ff == '0) begin
               low_in   = quo_ff[BW-1:0];
               state_in = ST_HIGH_GO;
            end
         end
         ST_HIGH_GO: begin
            if ({1'b0, samp_ff} > high_ff) begin
               div_load = 1'b1;
               load_num = NW'(samp_ff) * NW'(HIGH_MUL);
               load_den = DW'(BOUND_DIV);
               state_in = ST_HIGH_RUN;
            end else begin
               state_in = ST_AVG_GO;
            end
         end
         ST_HIGH_RUN: begin
            if (cnt_ff == '0) begin
               high_in  = quo_ff[BW-1:0];
               state_in = ST_AVG_GO;
            end
         end
         ST_AVG_GO: begin
            div_load = 1'b1;
            load_num = NW'(sum_ff);
            load_den = DW'(WINDOW_DEPTH);
            state_in = ST_AVG_RUN;
         end
         ST_AVG_RUN: begin
            if (cnt_ff == '0) begin
               avg_in   = quo_ff[SW-1:0];
               state_in = ST_SCALE_GO;
            end
         end
         ST_SCALE_GO: begin
            if (den_sv == '0) begin
               level_in = '0;
               empty_in = 1'b1;
               state_in = ST_OUT;
            end else if (num_sv == '0 || num_sv[BW] != den_sv[BW]) begin
               level_in = '0;
               empty_in = 1'b0;
               state_in = ST_OUT;
            end else begin
               empty_in = 1'b0;
               div_load = 1'b1;
               load_num = {num_mag, {LEVEL_BITS{1'b0}}} - NW'(num_mag);
               load_den = den_mag;
               state_in = ST_SCALE_RUN;
            end
         end
         ST_SCALE_RUN: begin
            if (cnt_ff == '0) begin
               level_in = (quo_ff > NW'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX)
                                                    : quo_ff[LEVEL_BITS-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_level_in   = level_ff;
               rsp_changed_in = ({1'b0, level_ff} != last_ff);
               rsp_empty_in   = empty_ff;
               last_in        = {1'b0, level_ff};
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (div_load) begin
         rem_in = '0;
         quo_in = load_num;
         div_in = load_den;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sum_ff       <= '0;
         low_ff       <= BW'(LOW_RESET);
         high_ff      <= BW'(HIGH_RESET);
         last_ff      <= NO_LEVEL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hist_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            hist_vld_ff[pos_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      samp_ff        <= samp_in;
      avg_ff         <= avg_in;
      level_ff       <= level_in;
      empty_ff       <= empty_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      div_ff         <= div_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_empty_ff   <= rsp_empty_in;
      if (accept) begin
         old_vld_ff <= hist_vld_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff            <= hist_mem[pos_ff];
         hist_mem[pos_ff]  <= req_sample;
      end
   end

endmodule

// ===== hdl/aras_checker.sv =====
// Port-level assertions for the auto-ranging average scaler and their bind.
`include "assert_macros.svh"

module aras_checker
   import aras_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LEVEL_BITS-1:0] rsp_level,
   input logic                  rsp_changed,
   input logic                  rsp_range_empty
);

   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) && $stable(rsp_changed) && $stable(rsp_range_empty), "Result changed while the receiver stalled.")
   `ASSERT_RST(a_empty_level_zero, clock, reset, rsp_valid && rsp_range_empty |-> rsp_level == '0, "An empty range gave a nonzero level.")
   `ASSERT_RST(a_busy_after_transfer, clock, reset, req_valid && req_ready |=> !req_ready, "A second sample was taken right after a transfer.")
   `ASSERT_ALWAYS(a_reset_state, clock, reset |=> !rsp_valid && req_ready, "The block was not empty and ready after reset.")

endmodule

bind auto_ranging_average_scaler aras_checker u_aras_checker (.*);

// ===== sim/auto_ranging_average_scaler_test.sv =====
// Self-checking testbench for the auto-ranging moving-average scaler.
`timescale 1ns / 100ps

module auto_ranging_average_scaler_test
   import aras_pkg::*;
;

   localparam int WINDOW_DEPTH = 16;
   localparam int SAMPLE_BITS  = 12;
   localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
   localparam int LOW_FLOOR    = 41;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 120;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  changed;
      logic                  range_empty;
   } level_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [LEVEL_BITS-1:0]  rsp_level;
   logic                   rsp_changed;
   logic                   rsp_range_empty;

   logic [SAMPLE_BITS-1:0] box_history [WINDOW_DEPTH];
   logic [15:0]            box_sum;
   logic [3:0]             box_pos;
   logic [SAMPLE_BITS:0]   range_low;
   logic [SAMPLE_BITS:0]   range_high;
   logic [LAST_BITS-1:0]   last_level;

   level_result_type expected_levels [$];

   bit idle_on = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int walk_samples = 0;
   int empty_seen = 0;
   int inverted_seen = 0;
   int clamped_seen = 0;

   auto_ranging_average_scaler #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_changed    (rsp_changed),
      .rsp_range_empty(rsp_range_empty)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results pending.",
                  cycle_count, expected_levels.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int clip_sample(input int value);
      if (value < 0) begin
         return 0;
      end
      if (value > SAMPLE_TOP) begin
         return SAMPLE_TOP;
      end
      return value;
   endfunction

   function automatic void next_bounds(input int smp, output int lo, output int hi);
      lo = int'(range_low);
      hi = int'(range_high);
      if (smp < lo) begin
         lo = smp * LOW_MUL / BOUND_DIV;
      end
      if (smp > hi) begin
         hi = smp * HIGH_MUL / BOUND_DIV;
      end
   endfunction

   function automatic void clear_scaler_state();
      foreach (box_history[i]) begin
         box_history[i] = '0;
      end
      box_sum    = '0;
      box_pos    = '0;
      range_low  = (SAMPLE_BITS + 1)'(LOW_RESET);
      range_high = (SAMPLE_BITS + 1)'(HIGH_RESET);
      last_level = NO_LEVEL;
   endfunction

   function automatic void predict_level(input logic [SAMPLE_BITS-1:0] smp);
      int lo;
      int hi;
      int avg;
      int num;
      int den;
      int scaled;
      level_result_type res;
      next_bounds(int'(smp), lo, hi);
      box_sum = box_sum - box_history[box_pos] + smp;
      box_history[box_pos] = smp;
      box_pos = box_pos + 1'b1;
      avg = int'(box_sum) / WINDOW_DEPTH;
      if (hi == lo) begin
         scaled = 0;
         res.range_empty = 1'b1;
         empty_seen++;
      end else begin
         num = (avg - lo) * LEVEL_MAX;
         den = hi - lo;
         scaled = num / den;
         if (hi < lo) begin
            inverted_seen++;
         end
         if (scaled < 0 || scaled > LEVEL_MAX) begin
            clamped_seen++;
         end
         if (scaled < 0) begin
            scaled = 0;
         end
         if (scaled > LEVEL_MAX) begin
            scaled = LEVEL_MAX;
         end
         res.range_empty = 1'b0;
      end
      res.level   = LEVEL_BITS'(scaled);
      res.changed = ({1'b0, res.level} != last_level);
      last_level  = {1'b0, res.level};
      range_low   = (SAMPLE_BITS + 1)'(lo);
      range_high  = (SAMPLE_BITS + 1)'(hi);
      expected_levels.push_back(res);
   endfunction

   // Looks for a sample that pulls one bound exactly onto the other.
   function automatic bit find_meeting_sample(output int smp);
      int base [2];
      int cand;
      int lo;
      int hi;
      base[0] = int'(range_high) * BOUND_DIV / LOW_MUL;
      base[1] = int'(range_low) * BOUND_DIV / HIGH_MUL;
      smp = 0;
      foreach (base[k]) begin
         for (int d = -2; d <= 3; d++) begin
            cand = base[k] + d;
            if (cand >= LOW_FLOOR && cand <= SAMPLE_TOP) begin
               next_bounds(cand, lo, hi);
               if (lo == hi) begin
                  smp = cand;
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   task automatic send_sample(input int value);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      predict_level(SAMPLE_BITS'(value));
      req_valid  <= 1'b1;
      req_sample <= SAMPLE_BITS'(value);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      level_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("result with no sample pending: level %0d", rsp_level));
         end else begin
            want = expected_levels.pop_front();
            results_checked++;
            if (rsp_level !== want.level) begin
               report_mismatch($sformatf("result %0d: level %0d, expected %0d",
                                         results_checked, rsp_level, want.level));
            end
            if (rsp_changed !== want.changed) begin
               report_mismatch($sformatf("result %0d: changed %b, expected %b",
                                         results_checked, rsp_changed, want.changed));
            end
            if (rsp_range_empty !== want.range_empty) begin
               report_mismatch($sformatf("result %0d: range_empty %b, expected %b",
                                         results_checked, rsp_range_empty,
                                         want.range_empty));
            end
         end
      end
   end

   // Reopens the range, then walks the two bounds toward each other until they meet,
   // and finally pushes them past each other into an inverted range.
   task automatic walk_episode();
      int meet;
      int steps;
      int before_count;
      bit reached;
      before_count = samples_sent;
      send_sample(SAMPLE_TOP);
      send_sample($urandom_range(LOW_FLOOR, 300));
      reached = 1'b0;
      steps = 0;
      while (!reached && range_low < range_high && steps < 200) begin
         steps++;
         if (find_meeting_sample(meet) && $urandom_range(0, 3) != 0) begin
            send_sample(meet);
            reached = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            send_sample($urandom_range(int'(range_low), int'(range_high)));
         end else if ($urandom_range(0, 1) == 1 && range_low >= LOW_FLOOR + 2) begin
            send_sample(clip_sample(int'(range_low) - 1 - $urandom_range(0, 1)));
         end else begin
            send_sample(clip_sample(int'(range_high) + 1 + $urandom_range(0, 1)));
         end
      end
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1) == 1) begin
            send_sample(clip_sample(int'(range_high) + 1));
         end else begin
            send_sample(clip_sample(int'(range_low) - 1));
         end
      end
      walk_samples += samples_sent - before_count;
   endtask

   task automatic test_extremes();
      int values [$];
      idle_on = 1'b1;
      values = '{300, 4095, 2730, 1365, 2048, 4094, 200, 3891, 4095, 4095, 4095, 4095,
                 4095, 4095, 1000, 1000, 1000};
      foreach (values[i]) begin
         send_sample(values[i]);
      end
   endtask

   task automatic test_empty_range();
      idle_on = 1'b0;
      walk_episode();
   endtask

   task automatic test_bound_walks(input int target);
      idle_on = 1'b1;
      walk_samples = 0;
      while (walk_samples < target) begin
         walk_episode();
      end
   endtask

   task automatic test_drain_pause();
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count);
      int corners [4];
      idle_on = 1'b1;
      corners = '{0, 1, SAMPLE_TOP - 1, SAMPLE_TOP};
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: begin
               send_sample(corners[$urandom_range(0, 3)]);
            end
            1, 2: begin
               send_sample($urandom_range(0, 63));
            end
            default: begin
               send_sample($urandom_range(0, SAMPLE_TOP));
            end
         endcase
      end
   endtask

   task automatic test_steady_stream(input int count);
      idle_on = 1'b0;
      repeat (count) begin
         send_sample($urandom_range(0, SAMPLE_TOP));
      end
   endtask

   initial begin
      clear_scaler_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_empty_range();
      test_bound_walks(330);
      test_drain_pause();
      test_random_traffic(150);
      test_steady_stream(100);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (expected_levels.size() != 0) begin
         report_mismatch("expected result never arrived");
         void'(expected_levels.pop_front());
      end

      $display("Sent %0d samples and checked %0d results; %0d mismatches.",
               samples_sent, results_checked, mismatches);
      $display("Empty range on %0d results, inverted range on %0d, clamped level on %0d.",
               empty_seen, inverted_seen, clamped_seen);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
